// ===== rtl/assert_macros.svh =====
// Assertion helpers for the files that carry checks (here polar_complex_add).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/pca_pkg.sv =====
package pca_pkg;

    localparam int DEF_MAG_BITS        = 16;
    localparam int DEF_PHASE_BITS      = 16;
    localparam int DEF_ROTATION_STAGES = 16;

    // Fraction bits kept below the magnitude LSB inside the CORDIC datapath.
    localparam int GUARD = 8;
    // Turn angles are 32-bit fractions of a full turn.
    localparam int TURN_BITS = 32;
    // Residual angle of the rotation pass, with headroom for the sign.
    localparam int Z_BITS = 34;

    // Inverse CORDIC gain, Q0.32.
    localparam logic [31:0] INV_GAIN     = 32'd2608131496;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:    t = 32'h2000_0000;
            5'd1:    t = 32'h12E4_051E;
            5'd2:    t = 32'h09FB_385B;
            5'd3:    t = 32'h0511_11D4;
            5'd4:    t = 32'h028B_0D43;
            5'd5:    t = 32'h0145_D7E1;
            5'd6:    t = 32'h00A2_F61E;
            5'd7:    t = 32'h0051_7C55;
            5'd8:    t = 32'h0028_BE53;
            5'd9:    t = 32'h0014_5F2F;
            5'd10:   t = 32'h000A_2F98;
            5'd11:   t = 32'h0005_17CC;
            5'd12:   t = 32'h0002_8BE6;
            5'd13:   t = 32'h0001_45F3;
            5'd14:   t = 32'h0000_A2FA;
            5'd15:   t = 32'h0000_517D;
            5'd16:   t = 32'h0000_28BE;
            5'd17:   t = 32'h0000_145F;
            5'd18:   t = 32'h0000_0A30;
            5'd19:   t = 32'h0000_0518;
            5'd20:   t = 32'h0000_028C;
            5'd21:   t = 32'h0000_0146;
            5'd22:   t = 32'h0000_00A3;
            5'd23:   t = 32'h0000_0051;
            5'd24:   t = 32'h0000_0029;
            5'd25:   t = 32'h0000_0014;
            5'd26:   t = 32'h0000_000A;
            5'd27:   t = 32'h0000_0005;
            5'd28:   t = 32'h0000_0003;
            5'd29:   t = 32'h0000_0001;
            5'd30:   t = 32'h0000_0001;
            default: t = 32'h0000_0000;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/polar_complex_add.sv =====
// Throughput: one request per cycle while the skid entry is free (o_in_ready high);
// each CORDIC iteration is its own register stage.
// The output register plus one skid entry let the pipeline run while a result waits.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
`include "assert_macros.svh"
module polar_complex_add import pca_pkg::*; #(
    parameter int MAG_BITS        = DEF_MAG_BITS,
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [MAG_BITS-1:0]          i_first_magnitude,
    input  logic signed [PHASE_BITS-1:0] i_first_phase,
    input  logic [MAG_BITS-1:0]          i_second_magnitude,
    input  logic signed [PHASE_BITS-1:0] i_second_phase,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [MAG_BITS:0]            o_sum_magnitude,
    output logic signed [PHASE_BITS-1:0] o_sum_phase
);

    // Datapath width: the vector sum stays below 2^(MAG_BITS+9) in guard units and
    // the vectoring gain is under two, so a few spare bits cover every pattern.
    localparam int W      = MAG_BITS + 12;
    // Upper slice of x fed to the high partial product of the final gain multiply.
    localparam int XH     = W - 16;
    localparam int PH_SH  = TURN_BITS - PHASE_BITS;
    localparam int MR_W   = W + 1 - GUARD;
    localparam logic [MR_W-1:0] MAG_LIM = MR_W'({(MAG_BITS+1){1'b1}});
    localparam logic [W:0]      MAG_RND = (W+1)'(1) << (GUARD - 1);

    // The whole pipeline moves together whenever the output buffer has room.
    logic w_en;
    assign o_in_ready = w_en;

    // ---------------------------------------------------------------------
    // Stage P0: scale the second magnitude by the inverse gain and fold the
    // phase difference into the right half plane. A difference in the back
    // half turn flips the start vector and takes half a turn off the angle.
    // ---------------------------------------------------------------------
    logic [MAG_BITS+31:0]   w_prod;
    logic [TURN_BITS-1:0]   w_p1, w_p2, w_d, w_d_red;
    logic                   w_d_neg;

    assign w_prod  = (MAG_BITS+32)'(i_second_magnitude) * (MAG_BITS+32)'(INV_GAIN);
    assign w_p1    = TURN_BITS'($unsigned(i_first_phase)) << PH_SH;
    assign w_p2    = TURN_BITS'($unsigned(i_second_phase)) << PH_SH;
    assign w_d     = w_p2 - w_p1;
    assign w_d_neg = (w_d + QUARTER_TURN) >= HALF_TURN;
    assign w_d_red = w_d_neg ? (w_d - HALF_TURN) : w_d;

    logic                     r_p0_valid;
    logic signed [W-1:0]      r_p0_w;
    logic                     r_p0_neg;
    logic signed [Z_BITS-1:0] r_p0_z;
    logic [MAG_BITS-1:0]      r_p0_r1;
    logic [PHASE_BITS-1:0]    r_p0_ph1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (w_en) begin
            r_p0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_w   <= signed'(W'(w_prod[MAG_BITS+31:TURN_BITS-GUARD]));
            r_p0_neg <= w_d_neg;
            r_p0_z   <= Z_BITS'(signed'(w_d_red));
            r_p0_r1  <= i_first_magnitude;
            r_p0_ph1 <= $unsigned(i_first_phase);
        end
    end

    // Stage P1: apply the half-turn flip to the start vector.
    logic                     r_p1_valid;
    logic signed [W-1:0]      r_p1_x;
    logic signed [Z_BITS-1:0] r_p1_z;
    logic [MAG_BITS-1:0]      r_p1_r1;
    logic [PHASE_BITS-1:0]    r_p1_ph1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= r_p0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_x   <= r_p0_neg ? -r_p0_w : r_p0_w;
            r_p1_z   <= r_p0_z;
            r_p1_r1  <= r_p0_r1;
            r_p1_ph1 <= r_p0_ph1;
        end
    end

    // ---------------------------------------------------------------------
    // Rotation pass: turns the second vector into the first one's frame.
    // The first magnitude and phase ride alongside in delay taps.
    // ---------------------------------------------------------------------
    logic                     w_rot_valid [ROTATION_STAGES+1];
    logic signed [W-1:0]      w_rot_x     [ROTATION_STAGES+1];
    logic signed [W-1:0]      w_rot_y     [ROTATION_STAGES+1];
    logic signed [Z_BITS-1:0] w_rot_z     [ROTATION_STAGES+1];
    logic [MAG_BITS-1:0]      r_rot_r1    [ROTATION_STAGES];
    logic [PHASE_BITS-1:0]    r_rot_ph1   [ROTATION_STAGES];

    assign w_rot_valid[0] = r_p1_valid;
    assign w_rot_x[0]     = r_p1_x;
    assign w_rot_y[0]     = '0;
    assign w_rot_z[0]     = r_p1_z;

    for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_rot
        pca_rot_stage #(
            .W     (W),
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rot_valid[k]),
            .i_x     (w_rot_x[k]),
            .i_y     (w_rot_y[k]),
            .i_z     (w_rot_z[k]),
            .o_valid (w_rot_valid[k+1]),
            .o_x     (w_rot_x[k+1]),
            .o_y     (w_rot_y[k+1]),
            .o_z     (w_rot_z[k+1])
        );

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rot_r1[k]  <= r_p1_r1;
                    r_rot_ph1[k] <= r_p1_ph1;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rot_r1[k]  <= r_rot_r1[k-1];
                    r_rot_ph1[k] <= r_rot_ph1[k-1];
                end
            end
        end
    end

    // Stage A: add the first vector, which lies on the real axis of its own frame.
    logic                  r_a_valid;
    logic signed [W-1:0]   r_a_x, r_a_y;
    logic [PHASE_BITS-1:0] r_a_ph1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_rot_valid[ROTATION_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_x   <= w_rot_x[ROTATION_STAGES] +
                       signed'(W'({r_rot_r1[ROTATION_STAGES-1], {GUARD{1'b0}}}));
            r_a_y   <= w_rot_y[ROTATION_STAGES];
            r_a_ph1 <= r_rot_ph1[ROTATION_STAGES-1];
        end
    end

    // Stage B: flag an exactly zero sum, and mirror a sum that points into the
    // left half plane so that vectoring starts from half a turn.
    logic                  r_b_valid;
    logic                  r_b_zero;
    logic signed [W-1:0]   r_b_x, r_b_y;
    logic [TURN_BITS-1:0]  r_b_a;
    logic [PHASE_BITS-1:0] r_b_ph1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_zero <= (r_a_x == '0) && (r_a_y == '0);
            r_b_x    <= r_a_x[W-1] ? -r_a_x : r_a_x;
            r_b_y    <= r_a_x[W-1] ? -r_a_y : r_a_y;
            r_b_a    <= r_a_x[W-1] ? HALF_TURN : '0;
            r_b_ph1  <= r_a_ph1;
        end
    end

    // ---------------------------------------------------------------------
    // Vectoring pass: length and angle of the sum.
    // ---------------------------------------------------------------------
    logic                  w_vec_valid [ROTATION_STAGES+1];
    logic signed [W-1:0]   w_vec_x     [ROTATION_STAGES+1];
    logic signed [W-1:0]   w_vec_y     [ROTATION_STAGES+1];
    logic [TURN_BITS-1:0]  w_vec_a     [ROTATION_STAGES+1];
    logic                  r_vec_zero  [ROTATION_STAGES];
    logic [PHASE_BITS-1:0] r_vec_ph1   [ROTATION_STAGES];

    assign w_vec_valid[0] = r_b_valid;
    assign w_vec_x[0]     = r_b_x;
    assign w_vec_y[0]     = r_b_y;
    assign w_vec_a[0]     = r_b_a;

    for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_vec
        pca_vec_stage #(
            .W     (W),
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vec_valid[k]),
            .i_x     (w_vec_x[k]),
            .i_y     (w_vec_y[k]),
            .i_a     (w_vec_a[k]),
            .o_valid (w_vec_valid[k+1]),
            .o_x     (w_vec_x[k+1]),
            .o_y     (w_vec_y[k+1]),
            .o_a     (w_vec_a[k+1])
        );

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_vec_zero[k] <= r_b_zero;
                    r_vec_ph1[k]  <= r_b_ph1;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_vec_zero[k] <= r_vec_zero[k-1];
                    r_vec_ph1[k]  <= r_vec_ph1[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage M1: remove the vectoring gain. x is never negative here, so it is
    // split into a high slice and a 16-bit low slice, each multiplied by the
    // Q0.32 inverse gain. The output phase sum is formed alongside.
    // ---------------------------------------------------------------------
    logic [XH-1:0]         w_x_hi;
    logic [15:0]           w_x_lo;

    assign w_x_hi = $unsigned(w_vec_x[ROTATION_STAGES][W-1:16]);
    assign w_x_lo = $unsigned(w_vec_x[ROTATION_STAGES][15:0]);

    logic                  r_m1_valid;
    logic                  r_m1_zero;
    logic [XH+31:0]        r_m1_hi;
    logic [47:0]           r_m1_lo;
    logic [TURN_BITS-1:0]  r_m1_ph;
    logic [PHASE_BITS-1:0] r_m1_ph1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= w_vec_valid[ROTATION_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_zero <= r_vec_zero[ROTATION_STAGES-1];
            r_m1_hi   <= (XH+32)'(w_x_hi) * (XH+32)'(INV_GAIN);
            r_m1_lo   <= 48'(w_x_lo) * 48'(INV_GAIN);
            r_m1_ph   <= (TURN_BITS'(r_vec_ph1[ROTATION_STAGES-1]) << PH_SH) +
                         w_vec_a[ROTATION_STAGES];
            r_m1_ph1  <= r_vec_ph1[ROTATION_STAGES-1];
        end
    end

    // Stage M2: combine the partial products (the product's top bits after a
    // 32-bit shift) and round the phase half up to the output width.
    logic [XH+31:0]        w_m_sum;
    logic [TURN_BITS-1:0]  w_ph_round;

    assign w_m_sum = r_m1_hi + (XH+32)'(r_m1_lo[47:16]);

    if (PH_SH > 0) begin : g_ph_round
        assign w_ph_round = r_m1_ph + (TURN_BITS'(1) << (PH_SH - 1));
    end else begin : g_ph_exact
        assign w_ph_round = r_m1_ph;
    end

    logic                  r_m2_valid;
    logic                  r_m2_zero;
    logic [W-1:0]          r_m2_m;
    logic [PHASE_BITS-1:0] r_m2_ph;
    logic [PHASE_BITS-1:0] r_m2_ph1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_zero <= r_m1_zero;
            r_m2_m    <= w_m_sum[XH+31:16];
            r_m2_ph   <= w_ph_round[TURN_BITS-1:PH_SH];
            r_m2_ph1  <= r_m1_ph1;
        end
    end

    // Stage M3: drop the guard bits with half-up rounding and saturate. A zero
    // sum reports zero length and keeps the first phase.
    logic [W:0]            w_m_rnd;
    logic [MR_W-1:0]       w_m_q;
    logic [MAG_BITS:0]     w_mag_sat;

    assign w_m_rnd   = (W+1)'(r_m2_m) + MAG_RND;
    assign w_m_q     = w_m_rnd[W:GUARD];
    assign w_mag_sat = (w_m_q > MAG_LIM) ? MAG_LIM[MAG_BITS:0] : w_m_q[MAG_BITS:0];

    logic                         r_m3_valid;
    logic [MAG_BITS:0]            r_m3_mag;
    logic signed [PHASE_BITS-1:0] r_m3_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (w_en) begin
            r_m3_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m3_mag <= r_m2_zero ? '0 : w_mag_sat;
            r_m3_ph  <= signed'(r_m2_zero ? r_m2_ph1 : r_m2_ph);
        end
    end

    // Output register and skid entry; its ready is what lets the pipeline move.
    pca_out_skid #(
        .MAG_BITS   (MAG_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m3_valid),
        .o_ready (w_en),
        .i_mag   (r_m3_mag),
        .i_phase (r_m3_ph),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_mag   (o_sum_magnitude),
        .o_phase (o_sum_phase)
    );

    // The pipeline only stops when a finished result is being held at the output.
    `ASSERT_IMP(a_stall_holds_result, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    // An accepted request occupies the first stage on the next edge.
    `ASSERT_NXT(a_request_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_p0_valid)
    // Vectoring only grows x from a non-negative start, so the gain multiply sees x >= 0.
    `ASSERT_IMP(a_vec_x_nonneg, i_clk, i_rst_n, w_vec_valid[ROTATION_STAGES],
                !w_vec_x[ROTATION_STAGES][W-1])

endmodule

// ===== rtl/pca_rot_stage.sv =====
// One CORDIC rotation step: drives the residual angle toward zero.
module pca_rot_stage import pca_pkg::*; #(
    parameter int W     = DEF_MAG_BITS + 12,
    parameter int STAGE = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [W-1:0]        i_x,
    input  logic signed [W-1:0]        i_y,
    input  logic signed [Z_BITS-1:0]   i_z,
    output logic                       o_valid,
    output logic signed [W-1:0]        o_x,
    output logic signed [W-1:0]        o_y,
    output logic signed [Z_BITS-1:0]   o_z
);

    localparam logic signed [Z_BITS-1:0] ANGLE =
        signed'(Z_BITS'(atan_turn(5'(STAGE))));

    logic                     r_valid;
    logic signed [W-1:0]      r_x, r_y, n_x, n_y;
    logic signed [Z_BITS-1:0] r_z, n_z;
    logic signed [W-1:0]      w_dx, w_dy;

    assign w_dx = i_y >>> STAGE;
    assign w_dy = i_x >>> STAGE;

    always_comb begin
        if (!i_z[Z_BITS-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== rtl/pca_vec_stage.sv =====
// One CORDIC vectoring step: drives y toward zero and accumulates the angle.
module pca_vec_stage import pca_pkg::*; #(
    parameter int W     = DEF_MAG_BITS + 12,
    parameter int STAGE = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [W-1:0]        i_x,
    input  logic signed [W-1:0]        i_y,
    input  logic [TURN_BITS-1:0]       i_a,
    output logic                       o_valid,
    output logic signed [W-1:0]        o_x,
    output logic signed [W-1:0]        o_y,
    output logic [TURN_BITS-1:0]       o_a
);

    localparam logic [TURN_BITS-1:0] ANGLE = atan_turn(5'(STAGE));

    logic                     r_valid;
    logic signed [W-1:0]      r_x, r_y, n_x, n_y;
    logic [TURN_BITS-1:0]     r_a, n_a;
    logic signed [W-1:0]      w_dx, w_dy;

    assign w_dx = i_y >>> STAGE;
    assign w_dy = i_x >>> STAGE;

    always_comb begin
        if (!i_y[W-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_a = i_a + ANGLE;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_a = i_a - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_a <= n_a;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_a     = r_a;

endmodule

// ===== rtl/pca_out_skid.sv =====
// Output register with one skid entry; the upstream ready is a flop.
module pca_out_skid import pca_pkg::*; #(
    parameter int MAG_BITS   = DEF_MAG_BITS,
    parameter int PHASE_BITS = DEF_PHASE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [MAG_BITS:0]            i_mag,
    input  logic signed [PHASE_BITS-1:0] i_phase,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [MAG_BITS:0]            o_mag,
    output logic signed [PHASE_BITS-1:0] o_phase
);

    logic                         r_out_valid, r_skid_valid;
    logic [MAG_BITS:0]            r_out_mag, r_skid_mag;
    logic signed [PHASE_BITS-1:0] r_out_phase, r_skid_phase;
    logic                         w_push, w_free;

    assign o_ready = !r_skid_valid;
    assign w_push  = i_valid && !r_skid_valid;
    assign w_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            r_out_valid  <= r_skid_valid || w_push;
            r_skid_valid <= 1'b0;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out_mag   <= r_skid_valid ? r_skid_mag : i_mag;
            r_out_phase <= r_skid_valid ? r_skid_phase : i_phase;
        end else if (w_push) begin
            r_skid_mag   <= i_mag;
            r_skid_phase <= i_phase;
        end
    end

    assign o_valid = r_out_valid;
    assign o_mag   = r_out_mag;
    assign o_phase = r_out_phase;

endmodule

// ===== test/pca_checker.sv =====
// Watches both channels of polar_complex_add, predicts each sum from the accepted request
// and compares it with the result that comes out, in order.
module pca_checker import pca_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [DEF_MAG_BITS-1:0]           i_first_magnitude,
    input  logic signed [DEF_PHASE_BITS-1:0]  i_first_phase,
    input  logic [DEF_MAG_BITS-1:0]           i_second_magnitude,
    input  logic signed [DEF_PHASE_BITS-1:0]  i_second_phase,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [DEF_MAG_BITS:0]             i_sum_magnitude,
    input  logic signed [DEF_PHASE_BITS-1:0]  i_sum_phase,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAG_W      = DEF_MAG_BITS;
    localparam int PHASE_W    = DEF_PHASE_BITS;
    localparam int ROT_STAGES = DEF_ROTATION_STAGES;
    localparam int FRAC_BITS  = 8;

    localparam logic [63:0] GAIN_RECIP = 64'd2608131496;
    localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
    localparam logic [31:0] TURN_QTR   = 32'h4000_0000;
    localparam logic [63:0] MAG_CEIL   = (64'd1 << (MAG_W + 1)) - 64'd1;

    typedef struct packed {
        logic [MAG_W:0]     mag;
        logic [PHASE_W-1:0] phase;
    } polar_sum_t;

    polar_sum_t expected_sums[$];

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [31:0] arctan_step(input int k);
        logic [31:0] v;
        case (k)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
            27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic polar_sum_t predict_sum(input logic [MAG_W-1:0] m1,
                                               input logic [PHASE_W-1:0] ph1,
                                               input logic [MAG_W-1:0] m2,
                                               input logic [PHASE_W-1:0] ph2);
        logic [63:0] r1, r2, xu, mag;
        logic [31:0] p1, p2, diff, ang, ph;
        logic signed [63:0] x, y, z, dx, dy, step;
        polar_sum_t res;
        int i;
        r1 = 64'(m1);
        r2 = 64'(m2);
        p1 = 32'(ph1) << (32 - PHASE_W);
        p2 = 32'(ph2) << (32 - PHASE_W);
        diff = p2 - p1;

        // Second vector, pre-scaled by the inverse gain, then turned by the phase difference.
        x = (r2 * GAIN_RECIP) >> (32 - FRAC_BITS);
        y = 0;
        if (((diff + TURN_QTR) & TURN_HALF) != 32'd0) begin
            x = -x;
            diff = diff - TURN_HALF;
        end
        z = {{32{diff[31]}}, diff};
        for (i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            step = {32'd0, arctan_step(i)};
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - step;
            end else begin
                x = x + dx; y = y - dy; z = z + step;
            end
        end

        x = x + $signed(r1 << FRAC_BITS);
        if (x == 0 && y == 0) begin
            res.mag = '0;
            res.phase = ph1;
            return res;
        end

        // Vectoring pass: drive y to zero and collect the angle.
        ang = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = TURN_HALF;
        end
        for (i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; ang = ang + arctan_step(i);
            end else begin
                x = x - dx; y = y + dy; ang = ang - arctan_step(i);
            end
        end

        xu = x;
        mag = ((xu >> 16) * GAIN_RECIP + (((xu & 64'hFFFF) * GAIN_RECIP) >> 16)) >> 16;
        mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (mag > MAG_CEIL) mag = MAG_CEIL;
        ph = p1 + ang;
        if (PHASE_W < 32) ph = (ph + (32'd1 << (31 - PHASE_W))) >> (32 - PHASE_W);
        res.mag = mag[MAG_W:0];
        res.phase = ph[PHASE_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        polar_sum_t want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_sums.push_back(predict_sum(i_first_magnitude, i_first_phase,
                                                    i_second_magnitude, i_second_phase));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: result with no request pending: magnitude %0d phase %0d",
                             $realtime, i_sum_magnitude, i_sum_phase);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_sums.pop_front();
                    o_checked = o_checked + 1;
                    if (i_sum_magnitude !== want.mag) begin
                        $display("%0t: sum_magnitude mismatch: expected %0d, actual %0d",
                                 $realtime, want.mag, i_sum_magnitude);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_sum_phase !== want.phase) begin
                        $display("%0t: sum_phase mismatch: expected %0d, actual %0d",
                                 $realtime, $signed(want.phase), i_sum_phase);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_sums.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the testbench: clock, reset, request stimulus and the result-side ready pattern.
// All prediction and comparison lives in pca_checker; this module only reads its counters.
module tb import pca_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAG_W        = DEF_MAG_BITS;
    localparam int PHASE_W      = DEF_PHASE_BITS;
    localparam int RANDOM_COUNT = 1850;
    // Drain wait: the pipeline depth plus a margin for the skid entry.
    localparam int DRAIN_CYCLES = 2 * DEF_ROTATION_STAGES + 8 + 16;
    // Worst case is roughly 1900 requests each seeing the longest gap and the longest stall,
    // plus the long hold-off; the limit is several times that.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [MAG_W-1:0]          first_mag;
    logic signed [PHASE_W-1:0] first_ph;
    logic [MAG_W-1:0]          second_mag;
    logic signed [PHASE_W-1:0] second_ph;
    logic                      out_valid;
    logic                      out_ready;
    logic [MAG_W:0]            sum_mag;
    logic signed [PHASE_W-1:0] sum_ph;

    int fail_count;
    int pending;
    int checked;
    int requests_sent = 0;
    int directed_count = 0;
    int cycle_count = 0;
    int hold_cnt = 0;
    int free_cnt = 0;
    bit hold_done = 0;

    polar_complex_add dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_first_magnitude  (first_mag),
        .i_first_phase      (first_ph),
        .i_second_magnitude (second_mag),
        .i_second_phase     (second_ph),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_sum_magnitude    (sum_mag),
        .o_sum_phase        (sum_ph)
    );

    pca_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_first_magnitude  (first_mag),
        .i_first_phase      (first_ph),
        .i_second_magnitude (second_mag),
        .i_second_phase     (second_ph),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_sum_magnitude    (sum_mag),
        .i_sum_phase        (sum_ph),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is bounded by a plain cycle counter; hitting it means something hung.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle length for either side: mostly zero or a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Magnitudes biased toward the edges of the Q1.15 range.
    function automatic logic [MAG_W-1:0] pick_magnitude();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return MAG_W'(1);
            2: return '1;
            3: return {1'b1, {(MAG_W-1){1'b0}}};
            4: return {{(MAG_W-1){1'b1}}, 1'b0};
            default: return MAG_W'($urandom);
        endcase
    endfunction

    // Presents one request and holds it until the block takes it. The task is entered and
    // left at a falling edge, so valid is touched at most once per time step: when there is
    // no gap, valid simply stays high while the payload moves on to the next request.
    task automatic send_request(input logic [MAG_W-1:0] m1, input logic [PHASE_W-1:0] p1,
                                input logic [MAG_W-1:0] m2, input logic [PHASE_W-1:0] p2,
                                input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        first_mag  <= m1;
        first_ph   <= p1;
        second_mag <= m2;
        second_ph  <= p2;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent = requests_sent + 1;
        @(negedge clk);
    endtask

    task automatic send_directed(input logic [MAG_W-1:0] m1, input logic [PHASE_W-1:0] p1,
                                 input logic [MAG_W-1:0] m2, input logic [PHASE_W-1:0] p2);
        send_request(m1, p1, m2, p2, pick_gap());
        directed_count = directed_count + 1;
    endtask

    // Result side. Ready follows alternating runs of stall and acceptance, counted here in
    // cycles. Once the random part is well under way, ready is held low for a long stretch
    // while requests keep coming, so the pipeline fills and the block has to drop in_ready.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cnt == 0 && free_cnt == 0) begin
                if (!hold_done && requests_sent >= 600) begin
                    hold_done = 1;
                    hold_cnt = HOLD_CYCLES;
                end else begin
                    hold_cnt = pick_gap();
                end
                free_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 6);
            end
            if (hold_cnt > 0) begin
                out_ready <= 1'b0;
                hold_cnt = hold_cnt - 1;
            end else begin
                out_ready <= 1'b1;
                free_cnt = free_cnt - 1;
            end
        end
    end

    initial begin
        logic [MAG_W-1:0]   m1, m2;
        logic [PHASE_W-1:0] p1, p2;
        int gap;
        int kind;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        first_mag  <= '0;
        first_ph   <= '0;
        second_mag <= '0;
        second_ph  <= '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Both magnitudes zero gives an exact zero sum, which must hand back
        // the first phase unchanged.
        send_directed(16'd0, 16'sd0, 16'd0, 16'sd0);
        send_directed(16'd0, 16'sd12345, 16'd0, -16'sd20000);
        send_directed(16'd0, -16'sd32768, 16'd0, 16'sd32767);
        // Largest magnitudes, aligned: the top of the Q2.15 range and the saturation limit.
        send_directed(16'hFFFF, 16'sd0, 16'hFFFF, 16'sd0);
        send_directed(16'hFFFF, 16'sd32767, 16'hFFFF, 16'sd32767);
        send_directed(16'hFFFF, -16'sd32768, 16'hFFFF, -16'sd32768);
        // Opposite phases with equal magnitudes, so the sum nearly cancels.
        send_directed(16'hFFFF, 16'sd0, 16'hFFFF, -16'sd32768);
        send_directed(16'd32768, -16'sd16384, 16'd32768, 16'sd16384);
        // A small first vector against a large opposite one puts the sum in the left half.
        send_directed(16'd100, 16'sd0, 16'hFFFF, -16'sd32768);
        send_directed(16'd1, 16'sd20000, 16'd50000, -16'sd12768);
        // Phase differences at and around a quarter turn, where the start vector gets flipped.
        send_directed(16'd40000, 16'sd0, 16'd40000, 16'sd16384);
        send_directed(16'd40000, 16'sd0, 16'd40000, 16'sd16383);
        send_directed(16'd40000, 16'sd16384, 16'd40000, 16'sd0);
        send_directed(16'd40000, 16'sd16385, 16'd40000, 16'sd0);
        // One operand zero.
        send_directed(16'd0, 16'sd5000, 16'hFFFF, -16'sd5000);
        send_directed(16'hFFFF, 16'sd1000, 16'd0, 16'sd9999);
        // Tiny values and an output phase that wraps past the top of the range.
        send_directed(16'd1, -16'sd1, 16'd1, 16'sd1);
        send_directed(16'hFFFF, 16'sd32767, 16'd1, -16'sd32768);
        send_directed(16'd12345, 16'sd8000, 16'd54321, -16'sd24000);

        // Random part. Every fourth window of 150 requests is sent back to back.
        for (int k = 0; k < RANDOM_COUNT; k++) begin
            kind = $urandom_range(0, 99);
            m1 = MAG_W'($urandom);
            m2 = MAG_W'($urandom);
            p1 = PHASE_W'($urandom);
            p2 = PHASE_W'($urandom);
            if (kind < 50) begin
                // Fully random fields.
            end else if (kind < 65) begin
                m1 = pick_magnitude();
                m2 = pick_magnitude();
            end else if (kind < 80) begin
                // Phase difference close to a quarter, half or three-quarter turn, or zero.
                case ($urandom_range(0, 3))
                    0: p2 = p1 + 16'sd16384;
                    1: p2 = p1 - 16'sd16384;
                    2: p2 = p1 + 16'h8000;
                    default: p2 = p1;
                endcase
                p2 = p2 + 16'($urandom_range(0, 6)) - 16'd3;
            end else if (kind < 90) begin
                // Near cancellation: equal or almost equal magnitudes, opposite phases.
                m2 = m1 + 16'($urandom_range(0, 4)) - 16'd2;
                p2 = p1 + 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1;
            end else begin
                if ($urandom_range(0, 2) != 0) m1 = '0;
                if ($urandom_range(0, 2) != 0) m2 = '0;
            end
            gap = ((k / 150) % 4 == 3) ? 0 : pick_gap();
            send_request(m1, p1, m2, p2, gap);
        end
        in_valid <= 1'b0;

        // Let every outstanding result come back, then give the pipeline time to show
        // anything it should not produce.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d directed and %0d random requests, %0d results compared,",
                 directed_count, requests_sent - directed_count, checked);
        $display("with random stalls on both sides and one %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pca_pkg.sv
rtl/pca_rot_stage.sv
rtl/pca_vec_stage.sv
rtl/pca_out_skid.sv
rtl/polar_complex_add.sv
test/pca_checker.sv
test/tb.sv
